>>> hw/rtl/clr_pkg.sv
package clr_pkg;

  typedef struct packed {
    logic signed [20:0] literal;
    logic               end_of_input;
  } clr_in_t;

  typedef struct packed {
    logic [1:0]         item_kind;
    logic signed [11:0] renamed_literal;
    logic               repeated_flag;
    logic               tautology_flag;
    logic               clause_kept;
    logic               clause_empty;
    logic [1:0]         final_status;
    logic               overflow_flag;
    logic [19:0]        kept_count;
  } clr_out_t;

  localparam logic [1:0] KIND_LITERAL = 2'd0;
  localparam logic [1:0] KIND_CLOSE   = 2'd1;
  localparam logic [1:0] KIND_FINAL   = 2'd2;

  localparam logic [1:0] STATUS_UNKNOWN = 2'd0;
  localparam logic [1:0] STATUS_SAT     = 2'd1;
  localparam logic [1:0] STATUS_UNSAT   = 2'd2;

  localparam logic [19:0] COUNT_MAX = 20'hFFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VSCAN,
    ST_CSCAN,
    ST_CWAIT,
    ST_EMIT
  } clr_state_t;

endpackage

>>> hw/rtl/cnf_literal_renamer_top.sv
// Literal renamer for a stream of tokenized CNF literals. Each input transfer
// yields exactly one result transfer. A nonzero literal holds off the next
// input transfer while the block works on it. It first runs a linear scan of
// the variable memory over the V variables seen so far, one entry per cycle,
// ending early when the variable is found. It then runs a linear scan of the
// clause memory over the L literals stored in the open clause. Each scan
// drains its last registered read. Both memories have one registered read
// port. A clause close or end-of-input passes only through the emit state.
// A result that waits in the output register holds off the next input
// transfer until it is taken.
module cnf_literal_renamer_top import clr_pkg::*; #(
  parameter int MAX_VARIABLES     = 1024,
  parameter int MAX_CLAUSE_LENGTH = 64,
  parameter int VARIABLE_BITS     = 20
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  clr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output clr_out_t out_data
);

  localparam int VA = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;
  localparam int VC = $clog2(MAX_VARIABLES + 1);
  localparam int CA = (MAX_CLAUSE_LENGTH > 1) ? $clog2(MAX_CLAUSE_LENGTH) : 1;
  localparam int CC = $clog2(MAX_CLAUSE_LENGTH + 1);
  localparam int IW = (VC > CC) ? VC : CC;
  localparam logic [VARIABLE_BITS-1:0] MAXV = {VARIABLE_BITS{1'b1}};

  // memories
  logic [VARIABLE_BITS-1:0] var_mem [MAX_VARIABLES];
  logic [11:0]              cls_mem [MAX_CLAUSE_LENGTH];
  logic [VARIABLE_BITS-1:0] var_rd_r;
  logic [11:0]              cls_rd_r;

  clr_state_t state_r, state_nxt;
  logic [VC-1:0] var_cnt_r, var_cnt_nxt;
  logic [CC-1:0] cls_len_r, cls_len_nxt;
  logic [IW-1:0] idx_r, idx_nxt;          // scan index issued
  logic          rdv_r, rdv_nxt;          // read data valid this cycle
  logic [VC-1:0] ridx_r, ridx_nxt;        // index of read data
  logic          drop_r, drop_nxt;
  logic          open_r, open_nxt;
  logic          empty_seen_r, empty_seen_nxt;
  logic [19:0]   cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [VARIABLE_BITS-1:0] mag_r, mag_nxt;
  logic          neg_r, neg_nxt;
  logic [11:0]   lit_r, lit_nxt;
  logic          named_r, named_nxt;
  logic          rep_r, rep_nxt, taut_r, taut_nxt;
  logic          out_valid_r, out_valid_nxt;
  clr_out_t      out_r, out_nxt;

  logic          var_we, cls_we;
  logic [VA-1:0] var_wa, var_ra;
  logic [CA-1:0] cls_wa, cls_ra;
  logic [VARIABLE_BITS-1:0] var_wd;
  logic [11:0]   cls_wd;

  // magnitude of the incoming literal with saturation
  logic [20:0] raw_mag;
  logic [VARIABLE_BITS-1:0] in_mag;
  always_comb begin
    raw_mag = in_data.literal[20] ? (21'd0 - in_data.literal) : in_data.literal;
    if (VARIABLE_BITS >= 21)
      in_mag = VARIABLE_BITS'(raw_mag);
    else if (raw_mag > 21'(MAXV))
      in_mag = MAXV;
    else
      in_mag = VARIABLE_BITS'(raw_mag);
  end

  always_ff @(posedge clk) begin
    if (var_we) var_mem[var_wa] <= var_wd;
    var_rd_r <= var_mem[var_ra];
    if (cls_we) cls_mem[cls_wa] <= cls_wd;
    cls_rd_r <= cls_mem[cls_ra];
  end

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic [19:0] cnt_inc;
  assign cnt_inc = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 20'd1;

  always_comb begin
    state_nxt = state_r; var_cnt_nxt = var_cnt_r; cls_len_nxt = cls_len_r;
    idx_nxt = idx_r; rdv_nxt = 1'b0; ridx_nxt = VC'(idx_r);
    drop_nxt = drop_r; open_nxt = open_r; empty_seen_nxt = empty_seen_r;
    cnt_nxt = cnt_r; ovf_nxt = ovf_r; mag_nxt = mag_r; neg_nxt = neg_r;
    lit_nxt = lit_r; named_nxt = named_r; rep_nxt = rep_r; taut_nxt = taut_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    var_we = 1'b0; var_wa = VA'(var_cnt_r); var_wd = mag_r;
    cls_we = 1'b0; cls_wa = CA'(cls_len_r); cls_wd = lit_r;
    var_ra = VA'(idx_r); cls_ra = CA'(idx_r);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          out_nxt = '0;
          if (in_data.end_of_input) begin
            out_nxt.item_kind = KIND_FINAL;
            out_nxt.clause_kept = open_r;
            out_nxt.final_status = open_r ? (empty_seen_r ? STATUS_UNSAT : STATUS_UNKNOWN)
                                 : ((cnt_r == 20'd0) ? STATUS_SAT
                                 : (empty_seen_r ? STATUS_UNSAT : STATUS_UNKNOWN));
            out_nxt.overflow_flag = ovf_r;
            out_nxt.kept_count = open_r ? cnt_inc : cnt_r;
            state_nxt = ST_EMIT;
            var_cnt_nxt = '0; cls_len_nxt = '0; drop_nxt = 1'b0; open_nxt = 1'b0;
            empty_seen_nxt = 1'b0; cnt_nxt = '0; ovf_nxt = 1'b0;
          end else if (in_data.literal == 21'sd0) begin
            out_nxt.item_kind = KIND_CLOSE;
            out_nxt.clause_empty = !open_r;
            out_nxt.clause_kept = !drop_r;
            if (!open_r) empty_seen_nxt = 1'b1;
            if (!drop_r) cnt_nxt = cnt_inc;
            out_nxt.overflow_flag = ovf_r;
            out_nxt.kept_count = drop_r ? cnt_r : cnt_inc;
            cls_len_nxt = '0; drop_nxt = 1'b0; open_nxt = 1'b0;
            state_nxt = ST_EMIT;
          end else begin
            mag_nxt = in_mag; neg_nxt = in_data.literal[20];
            open_nxt = 1'b1; named_nxt = 1'b0;
            rep_nxt = 1'b0; taut_nxt = 1'b0;
            idx_nxt = '0;
            state_nxt = ST_VSCAN;
          end
        end
      end
      ST_VSCAN: begin
        // issue read at idx, compare data from previous read
        if (rdv_r && var_rd_r == mag_r) begin
          named_nxt = 1'b1;
          lit_nxt = neg_r ? -(12'(ridx_r) + 12'd1) : 12'(ridx_r) + 12'd1;
          idx_nxt = '0; state_nxt = ST_CSCAN;
        end else if (idx_r < IW'(var_cnt_r)) begin
          rdv_nxt = 1'b1; ridx_nxt = VC'(idx_r); idx_nxt = idx_r + IW'(1);
        end else if (rdv_r) begin
          // last read compared without a match; enter the variable next cycle
          rdv_nxt = 1'b0;
        end else begin
          idx_nxt = '0;
          if (var_cnt_r < VC'(MAX_VARIABLES)) begin
            var_we = 1'b1;
            var_cnt_nxt = var_cnt_r + VC'(1);
            named_nxt = 1'b1;
            lit_nxt = neg_r ? -(12'(var_cnt_r) + 12'd1) : 12'(var_cnt_r) + 12'd1;
            state_nxt = ST_CSCAN;
          end else begin
            ovf_nxt = 1'b1;
            state_nxt = ST_CWAIT;
          end
        end
      end
      ST_CSCAN: begin
        if (rdv_r) begin
          if (cls_rd_r == lit_r) rep_nxt = 1'b1;
          if (cls_rd_r == 12'(-lit_r)) taut_nxt = 1'b1;
        end
        if (idx_r < IW'(cls_len_r)) begin
          rdv_nxt = 1'b1; idx_nxt = idx_r + IW'(1);
        end else if (!rdv_r) begin
          state_nxt = ST_CWAIT;
        end
      end
      default: begin // ST_CWAIT, ST_EMIT
        if (state_r == ST_CWAIT) begin
          out_nxt = '0;
          out_nxt.item_kind = KIND_LITERAL;
          if (named_r) begin
            out_nxt.renamed_literal = lit_r;
            out_nxt.repeated_flag = rep_r;
            out_nxt.tautology_flag = taut_r;
            if (taut_r) drop_nxt = 1'b1;
            if (!rep_r) begin
              if (cls_len_r < CC'(MAX_CLAUSE_LENGTH)) begin
                cls_we = 1'b1; cls_len_nxt = cls_len_r + CC'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
          end
          out_nxt.overflow_flag = ovf_nxt;
          out_nxt.kept_count = cnt_r;
        end
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; var_cnt_r <= '0; cls_len_r <= '0; idx_r <= '0;
      rdv_r <= 1'b0; drop_r <= 1'b0; open_r <= 1'b0; empty_seen_r <= 1'b0;
      cnt_r <= '0; ovf_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; var_cnt_r <= var_cnt_nxt; cls_len_r <= cls_len_nxt;
      idx_r <= idx_nxt; rdv_r <= rdv_nxt; drop_r <= drop_nxt; open_r <= open_nxt;
      empty_seen_r <= empty_seen_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r <= ridx_nxt; mag_r <= mag_nxt; neg_r <= neg_nxt; lit_r <= lit_nxt;
    named_r <= named_nxt; rep_r <= rep_nxt; taut_r <= taut_nxt; out_r <= out_nxt;
  end

endmodule

>>> hw/rtl/clr_checker.sv
module clr_checker import clr_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input clr_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input clr_out_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // an accepted item stalls the input in the next cycle
  a_in_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // a final status result carries no literal
  a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == KIND_FINAL |-> out_data.renamed_literal == 12'sd0)
    else $error("final result carries a literal");

  // a close result never flags literals
  a_close_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == KIND_CLOSE
    |-> !out_data.repeated_flag && !out_data.tautology_flag)
    else $error("close result flags literal");

endmodule

bind cnf_literal_renamer_top clr_checker u_clr_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);
